// ----- rtl/plma_pkg.sv -----
// Shared types and constants for the power limit min arbiter.
package plma_pkg;

  localparam int KIND_BITS   = 2;
  localparam int POLICY_BITS = 4;
  localparam int TYPE_BITS   = 2;
  localparam int FIELD_BITS  = 24;
  localparam int DUTY_BITS   = 7;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_BEGIN  = 2'd0,
    KIND_ENTRY  = 2'd1,
    KIND_COMMIT = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic begin_set;
    logic drop;
    logic entry;
    logic walk_start;
    logic issue;
    logic emit_start;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic issue_last;
    logic emit_last;
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/plma_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module plma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ----- rtl/plma_ctrl.sv -----
// Controller state machine: request decode, commit walk, result emission.
module plma_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  plma_pkg::kind_t        in_kind,
  input  plma_pkg::dp_status_t   status,
  output plma_pkg::ctrl_cmd_t    cmd
);
  import plma_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_kind == KIND_COMMIT) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (status.issue_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free && status.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            KIND_BEGIN: begin
              cmd.begin_set = 1'b1;
              cmd.drop      = 1'b1;
            end
            KIND_ENTRY: begin
              cmd.entry = 1'b1;
            end
            KIND_COMMIT: begin
              cmd.walk_start = 1'b1;
            end
            KIND_CLEAR: begin
              cmd.drop = 1'b1;
            end
            default: begin
              cmd = '0;
            end
          endcase
        end
      end
      ST_WALK: begin
        cmd.issue = 1'b1;
      end
      ST_DRAIN: begin
        cmd.emit_start = 1'b1;
      end
      ST_EMIT: begin
        cmd.load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- rtl/plma_dpath.sv -----
// Datapath: request store, min resolution, resolved set and output register.
module plma_dpath #(
  parameter int NUM_POLICIES = 16,
  parameter int NUM_TYPES    = 3,
  parameter int POWER_BITS   = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  plma_pkg::ctrl_cmd_t                 cmd,
  output plma_pkg::dp_status_t                status,
  input  logic [plma_pkg::POLICY_BITS-1:0]    in_policy,
  input  logic [plma_pkg::TYPE_BITS-1:0]      in_ctrl_type,
  input  logic                                in_power_valid,
  input  logic [plma_pkg::FIELD_BITS-1:0]     in_power_mw,
  input  logic                                in_window_valid,
  input  logic [plma_pkg::FIELD_BITS-1:0]     in_window_ms,
  input  logic                                in_duty_valid,
  input  logic [plma_pkg::DUTY_BITS-1:0]      in_duty_pct,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [plma_pkg::TYPE_BITS-1:0]      out_type,
  output logic                                out_res_power_valid,
  output logic [plma_pkg::FIELD_BITS-1:0]     out_res_power_mw,
  output logic                                out_res_window_valid,
  output logic [plma_pkg::FIELD_BITS-1:0]     out_res_window_ms,
  output logic                                out_res_duty_valid,
  output logic [plma_pkg::DUTY_BITS-1:0]      out_res_duty_pct,
  output logic                                out_changed,
  output logic                                out_last
);
  import plma_pkg::*;

  localparam int PIW   = (NUM_POLICIES > 1) ? $clog2(NUM_POLICIES) : 1;
  localparam int TIW   = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int PW    = (POWER_BITS < FIELD_BITS) ? POWER_BITS : FIELD_BITS;
  localparam int AW    = PIW + TIW;
  localparam int DEPTH = 1 << AW;
  localparam int DW    = 3 + PW + FIELD_BITS + DUTY_BITS;
  localparam int DV_POS = DUTY_BITS;
  localparam int WIN_LO = DUTY_BITS + 1;
  localparam int WV_POS = WIN_LO + FIELD_BITS;
  localparam int PW_LO  = WV_POS + 1;
  localparam int PV_POS = PW_LO + PW;

  // policy-level state
  logic [POLICY_BITS-1:0] open_policy_r;
  logic [NUM_TYPES-1:0]   type_seen_r;
  logic [NUM_TYPES-1:0]   present_r [NUM_POLICIES];

  logic [TIW-1:0] ent_t;
  logic [PIW-1:0] open_idx;
  logic [PIW-1:0] drop_idx;
  logic           type_ok;
  logic           open_ok;
  logic           drop_ok;
  logic           ent_we;
  logic [DW-1:0]  wdata;
  logic [DW-1:0]  rdata;

  assign ent_t    = TIW'(in_ctrl_type);
  assign open_idx = PIW'(open_policy_r);
  assign drop_idx = PIW'(in_policy);
  assign type_ok  = 32'(in_ctrl_type) < NUM_TYPES;
  assign open_ok  = 32'(open_policy_r) < NUM_POLICIES;
  assign drop_ok  = 32'(in_policy) < NUM_POLICIES;
  assign ent_we   = cmd.entry && type_ok && open_ok && !type_seen_r[ent_t];

  assign wdata = {in_power_valid,
                  in_power_valid ? in_power_mw[PW-1:0] : {PW{1'b0}},
                  in_window_valid,
                  in_window_valid ? in_window_ms : {FIELD_BITS{1'b0}},
                  in_duty_valid,
                  in_duty_valid ? in_duty_pct : {DUTY_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_policy_r <= '0;
      type_seen_r   <= '0;
      for (int p = 0; p < NUM_POLICIES; p++) begin
        present_r[p] <= '0;
      end
    end else begin
      if (cmd.begin_set) begin
        open_policy_r <= in_policy;
        type_seen_r   <= '0;
      end
      if (cmd.drop && drop_ok) begin
        present_r[drop_idx] <= '0;
      end
      if (ent_we) begin
        present_r[open_idx][ent_t] <= 1'b1;
        type_seen_r[ent_t]         <= 1'b1;
      end
    end
  end

  // commit walk: type-major, policy-minor
  logic [PIW-1:0] pol_cnt_r;
  logic [TIW-1:0] typ_cnt_r;
  logic           pol_last;
  logic           typ_last;
  logic           rd_v_r;
  logic           rd_end_r;
  logic           rd_pres_r;
  logic [TIW-1:0] rd_type_r;

  assign pol_last = (pol_cnt_r == PIW'(NUM_POLICIES - 1));
  assign typ_last = (typ_cnt_r == TIW'(NUM_TYPES - 1));

  plma_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ent_we),
    .waddr ({ent_t, open_idx}),
    .wdata (wdata),
    .raddr ({typ_cnt_r, pol_cnt_r}),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pol_cnt_r <= '0;
      typ_cnt_r <= '0;
      rd_v_r    <= 1'b0;
    end else begin
      rd_v_r <= cmd.issue;
      if (cmd.walk_start) begin
        pol_cnt_r <= '0;
        typ_cnt_r <= '0;
      end else if (cmd.issue) begin
        if (pol_last) begin
          pol_cnt_r <= '0;
          typ_cnt_r <= typ_last ? '0 : typ_cnt_r + 1'b1;
        end else begin
          pol_cnt_r <= pol_cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_end_r  <= pol_last;
    rd_type_r <= typ_cnt_r;
    rd_pres_r <= present_r[pol_cnt_r][typ_cnt_r];
  end

  // running minimum
  logic                  acc_pv_r, acc_wv_r, acc_dv_r;
  logic [PW-1:0]         acc_pw_r;
  logic [FIELD_BITS-1:0] acc_win_r;
  logic [DUTY_BITS-1:0]  acc_duty_r;

  logic                  e_pv, e_wv, take_p, take_w;
  logic                  m_pv, m_wv, m_dv;
  logic [PW-1:0]         m_pw;
  logic [FIELD_BITS-1:0] m_win;
  logic [DUTY_BITS-1:0]  m_duty;
  logic                  differ;

  logic                  prev_pv_r   [NUM_TYPES];
  logic [PW-1:0]         prev_pw_r   [NUM_TYPES];
  logic                  prev_wv_r   [NUM_TYPES];
  logic [FIELD_BITS-1:0] prev_win_r  [NUM_TYPES];
  logic                  prev_dv_r   [NUM_TYPES];
  logic [DUTY_BITS-1:0]  prev_duty_r [NUM_TYPES];
  logic                  changed_r;

  assign e_pv   = rd_pres_r && rdata[PV_POS];
  assign e_wv   = rd_pres_r && rdata[WV_POS];
  assign take_p = e_pv && (!acc_pv_r || rdata[PV_POS-1:PW_LO] < acc_pw_r);
  assign take_w = e_wv && (!acc_wv_r || rdata[WV_POS-1:WIN_LO] < acc_win_r);
  assign m_pv   = acc_pv_r || e_pv;
  assign m_pw   = take_p ? rdata[PV_POS-1:PW_LO] : acc_pw_r;
  assign m_dv   = take_p ? rdata[DV_POS] : acc_dv_r;
  assign m_duty = take_p ? rdata[DUTY_BITS-1:0] : acc_duty_r;
  assign m_wv   = acc_wv_r || e_wv;
  assign m_win  = take_w ? rdata[WV_POS-1:WIN_LO] : acc_win_r;

  assign differ = (m_pv != prev_pv_r[rd_type_r]) || (m_pw != prev_pw_r[rd_type_r]) ||
                  (m_wv != prev_wv_r[rd_type_r]) || (m_win != prev_win_r[rd_type_r]) ||
                  (m_dv != prev_dv_r[rd_type_r]) || (m_duty != prev_duty_r[rd_type_r]);

  always_ff @(posedge clk) begin
    if (cmd.walk_start || (rd_v_r && rd_end_r)) begin
      acc_pv_r   <= 1'b0;
      acc_pw_r   <= '0;
      acc_wv_r   <= 1'b0;
      acc_win_r  <= '0;
      acc_dv_r   <= 1'b0;
      acc_duty_r <= '0;
    end else if (rd_v_r) begin
      acc_pv_r   <= m_pv;
      acc_pw_r   <= m_pw;
      acc_wv_r   <= m_wv;
      acc_win_r  <= m_win;
      acc_dv_r   <= m_dv;
      acc_duty_r <= m_duty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      changed_r <= 1'b0;
      for (int t = 0; t < NUM_TYPES; t++) begin
        prev_pv_r[t]   <= 1'b0;
        prev_pw_r[t]   <= '0;
        prev_wv_r[t]   <= 1'b0;
        prev_win_r[t]  <= '0;
        prev_dv_r[t]   <= 1'b0;
        prev_duty_r[t] <= '0;
      end
    end else begin
      if (cmd.walk_start) begin
        changed_r <= 1'b0;
      end else if (rd_v_r && rd_end_r) begin
        changed_r              <= changed_r || differ;
        prev_pv_r[rd_type_r]   <= m_pv;
        prev_pw_r[rd_type_r]   <= m_pw;
        prev_wv_r[rd_type_r]   <= m_wv;
        prev_win_r[rd_type_r]  <= m_win;
        prev_dv_r[rd_type_r]   <= m_dv;
        prev_duty_r[rd_type_r] <= m_duty;
      end
    end
  end

  // result emission
  logic [TIW-1:0]        emit_idx_r;
  logic                  emit_last;
  logic                  out_valid_r, out_valid_nxt;
  logic [TYPE_BITS-1:0]  out_type_r;
  logic                  out_pv_r, out_wv_r, out_dv_r, out_changed_r, out_last_r;
  logic [PW-1:0]         out_pw_r;
  logic [FIELD_BITS-1:0] out_win_r;
  logic [DUTY_BITS-1:0]  out_duty_r;

  assign emit_last     = (emit_idx_r == TIW'(NUM_TYPES - 1));
  assign out_valid_nxt = cmd.load || (out_valid_r && out_stall);

  assign status.issue_last = pol_last && typ_last;
  assign status.emit_last  = emit_last;
  assign status.out_free   = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.emit_start) begin
        emit_idx_r <= '0;
      end else if (cmd.load) begin
        emit_idx_r <= emit_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_type_r    <= TYPE_BITS'(emit_idx_r);
      out_pv_r      <= prev_pv_r[emit_idx_r];
      out_pw_r      <= prev_pw_r[emit_idx_r];
      out_wv_r      <= prev_wv_r[emit_idx_r];
      out_win_r     <= prev_win_r[emit_idx_r];
      out_dv_r      <= prev_dv_r[emit_idx_r];
      out_duty_r    <= prev_duty_r[emit_idx_r];
      out_changed_r <= changed_r;
      out_last_r    <= emit_last;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_type             = out_type_r;
  assign out_res_power_valid  = out_pv_r;
  assign out_res_power_mw     = FIELD_BITS'(out_pw_r);
  assign out_res_window_valid = out_wv_r;
  assign out_res_window_ms    = out_win_r;
  assign out_res_duty_valid   = out_dv_r;
  assign out_res_duty_pct     = out_duty_r;
  assign out_changed          = out_changed_r;
  assign out_last             = out_last_r;

endmodule

// ----- rtl/power_limit_min_arbiter.sv -----
// Top level of the power limit min arbiter.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  kind, policy, ctrl_type, power, window, duty
//   out_     output     out_valid/out_stall type, resolved power/window/duty, changed, last
//
// Begin, entry and clear requests are taken directly in the idle state.
// Commit walks the request RAM one entry per cycle: NUM_TYPES * NUM_POLICIES
// reads, a drain state, then one result per type, held back while out_stall holds.
// in_stall stays high from commit until the last result enters the output register.
// Reset is synchronous; no clearing pass, the RAM is masked by per-entry present bits.
module power_limit_min_arbiter #(
  parameter int NUM_POLICIES = 16,
  parameter int NUM_TYPES    = 3,
  parameter int POWER_BITS   = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [plma_pkg::KIND_BITS-1:0]   in_kind,
  input  logic [plma_pkg::POLICY_BITS-1:0] in_policy,
  input  logic [plma_pkg::TYPE_BITS-1:0]   in_ctrl_type,
  input  logic                             in_power_valid,
  input  logic [plma_pkg::FIELD_BITS-1:0]  in_power_mw,
  input  logic                             in_window_valid,
  input  logic [plma_pkg::FIELD_BITS-1:0]  in_window_ms,
  input  logic                             in_duty_valid,
  input  logic [plma_pkg::DUTY_BITS-1:0]   in_duty_pct,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [plma_pkg::TYPE_BITS-1:0]   out_type,
  output logic                             out_res_power_valid,
  output logic [plma_pkg::FIELD_BITS-1:0]  out_res_power_mw,
  output logic                             out_res_window_valid,
  output logic [plma_pkg::FIELD_BITS-1:0]  out_res_window_ms,
  output logic                             out_res_duty_valid,
  output logic [plma_pkg::DUTY_BITS-1:0]   out_res_duty_pct,
  output logic                             out_changed,
  output logic                             out_last
);
  import plma_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  plma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_kind  (kind_t'(in_kind)),
    .status   (status),
    .cmd      (cmd)
  );

  plma_dpath #(
    .NUM_POLICIES (NUM_POLICIES),
    .NUM_TYPES    (NUM_TYPES),
    .POWER_BITS   (POWER_BITS)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_policy            (in_policy),
    .in_ctrl_type         (in_ctrl_type),
    .in_power_valid       (in_power_valid),
    .in_power_mw          (in_power_mw),
    .in_window_valid      (in_window_valid),
    .in_window_ms         (in_window_ms),
    .in_duty_valid        (in_duty_valid),
    .in_duty_pct          (in_duty_pct),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_type             (out_type),
    .out_res_power_valid  (out_res_power_valid),
    .out_res_power_mw     (out_res_power_mw),
    .out_res_window_valid (out_res_window_valid),
    .out_res_window_ms    (out_res_window_ms),
    .out_res_duty_valid   (out_res_duty_valid),
    .out_res_duty_pct     (out_res_duty_pct),
    .out_changed          (out_changed),
    .out_last             (out_last)
  );

endmodule

// ----- tb/sv/tb_power_limit_min_arbiter.sv -----
// Testbench for power_limit_min_arbiter: directed and random requests checked against a model.
`timescale 1ns / 100ps

module tb_power_limit_min_arbiter;
  import plma_pkg::*;

  localparam int NUM_POLICIES     = 16;
  localparam int NUM_TYPES        = 3;
  localparam int RANDOM_REQUESTS  = 64;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int END_SETTLE       = 60;

  typedef struct {
    kind_t                  kind;
    logic [POLICY_BITS-1:0] policy;
    logic [TYPE_BITS-1:0]   ctrl_type;
    logic                   power_valid;
    logic [FIELD_BITS-1:0]  power_mw;
    logic                   window_valid;
    logic [FIELD_BITS-1:0]  window_ms;
    logic                   duty_valid;
    logic [DUTY_BITS-1:0]   duty_pct;
    bit                     drain_first;
  } plma_request_t;

  typedef struct packed {
    logic                  pv;
    logic [FIELD_BITS-1:0] pw;
    logic                  wv;
    logic [FIELD_BITS-1:0] win;
    logic                  dv;
    logic [DUTY_BITS-1:0]  duty;
  } limit_t;

  typedef struct {
    logic [TYPE_BITS-1:0] ltype;
    limit_t               lim;
    logic                 changed;
    logic                 last;
  } resolved_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [KIND_BITS-1:0]   in_kind = '0;
  logic [POLICY_BITS-1:0] in_policy = '0;
  logic [TYPE_BITS-1:0]   in_ctrl_type = '0;
  logic                   in_power_valid = 1'b0;
  logic [FIELD_BITS-1:0]  in_power_mw = '0;
  logic                   in_window_valid = 1'b0;
  logic [FIELD_BITS-1:0]  in_window_ms = '0;
  logic                   in_duty_valid = 1'b0;
  logic [DUTY_BITS-1:0]   in_duty_pct = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [TYPE_BITS-1:0]   out_type;
  logic                   out_res_power_valid;
  logic [FIELD_BITS-1:0]  out_res_power_mw;
  logic                   out_res_window_valid;
  logic [FIELD_BITS-1:0]  out_res_window_ms;
  logic                   out_res_duty_valid;
  logic [DUTY_BITS-1:0]   out_res_duty_pct;
  logic                   out_changed;
  logic                   out_last;

  power_limit_min_arbiter dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_kind              (in_kind),
    .in_policy            (in_policy),
    .in_ctrl_type         (in_ctrl_type),
    .in_power_valid       (in_power_valid),
    .in_power_mw          (in_power_mw),
    .in_window_valid      (in_window_valid),
    .in_window_ms         (in_window_ms),
    .in_duty_valid        (in_duty_valid),
    .in_duty_pct          (in_duty_pct),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_type             (out_type),
    .out_res_power_valid  (out_res_power_valid),
    .out_res_power_mw     (out_res_power_mw),
    .out_res_window_valid (out_res_window_valid),
    .out_res_window_ms    (out_res_window_ms),
    .out_res_duty_valid   (out_res_duty_valid),
    .out_res_duty_pct     (out_res_duty_pct),
    .out_changed          (out_changed),
    .out_last             (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Arbiter model state
  bit                     req_present [NUM_POLICIES][NUM_TYPES];
  limit_t                 req_limits [NUM_POLICIES][NUM_TYPES];
  limit_t                 last_resolved [NUM_TYPES];
  logic [POLICY_BITS-1:0] active_policy;
  logic [NUM_TYPES-1:0]   types_taken;

  plma_request_t pending_requests[$];
  resolved_t     resolved_expected[$];
  plma_request_t offered;

  int unsigned requests_taken;
  int unsigned commits_taken;
  int unsigned results_checked;
  int unsigned mismatches;
  int          burst_left;
  int          gap_left;
  int          hold_left;
  bit          long_hold_done;
  int unsigned stall_tick;
  int unsigned stall_mode;

  initial begin
    for (int p = 0; p < NUM_POLICIES; p++)
      for (int t = 0; t < NUM_TYPES; t++)
        req_present[p][t] = 1'b0;
    for (int t = 0; t < NUM_TYPES; t++)
      last_resolved[t] = '0;
    active_policy = '0;
    types_taken = '0;
  end

  function automatic void queue_request(input plma_request_t r);
    pending_requests = {pending_requests, r};
  endfunction

  function automatic void drop_requests(input logic [POLICY_BITS-1:0] p);
    for (int t = 0; t < NUM_TYPES; t++)
      req_present[p][t] = 1'b0;
  endfunction

  function automatic void resolve_request(input plma_request_t r);
    limit_t    res [NUM_TYPES];
    limit_t    e;
    resolved_t o;
    bit        diff;
    case (r.kind)
      KIND_BEGIN: begin
        active_policy = r.policy;
        types_taken = '0;
        drop_requests(r.policy);
      end
      KIND_CLEAR: begin
        drop_requests(r.policy);
      end
      KIND_ENTRY: begin
        if (r.ctrl_type < NUM_TYPES && !types_taken[r.ctrl_type]) begin
          types_taken[r.ctrl_type] = 1'b1;
          e.pv   = r.power_valid;
          e.pw   = r.power_valid ? r.power_mw : '0;
          e.wv   = r.window_valid;
          e.win  = r.window_valid ? r.window_ms : '0;
          e.dv   = r.duty_valid;
          e.duty = r.duty_valid ? r.duty_pct : '0;
          req_present[active_policy][r.ctrl_type] = 1'b1;
          req_limits[active_policy][r.ctrl_type] = e;
        end
      end
      KIND_COMMIT: begin
        diff = 1'b0;
        commits_taken++;
        for (int t = 0; t < NUM_TYPES; t++) begin
          res[t] = '0;
          for (int p = 0; p < NUM_POLICIES; p++) begin
            if (req_present[p][t]) begin
              e = req_limits[p][t];
              if (e.pv && (!res[t].pv || e.pw < res[t].pw)) begin
                res[t].pv   = 1'b1;
                res[t].pw   = e.pw;
                res[t].dv   = e.dv;
                res[t].duty = e.duty;
              end
              if (e.wv && (!res[t].wv || e.win < res[t].win)) begin
                res[t].wv  = 1'b1;
                res[t].win = e.win;
              end
            end
          end
          if (res[t] != last_resolved[t]) diff = 1'b1;
        end
        for (int t = 0; t < NUM_TYPES; t++) begin
          o.ltype   = TYPE_BITS'(t);
          o.lim     = res[t];
          o.changed = diff;
          o.last    = (t == NUM_TYPES - 1);
          resolved_expected = {resolved_expected, o};
          last_resolved[t] = res[t];
        end
      end
      default: ;
    endcase
  endfunction

  // Mostly small values so that ties and near-ties show up
  function automatic logic [FIELD_BITS-1:0] pick_limit_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return FIELD_BITS'($urandom_range(0, 15));
      4: return FIELD_BITS'($urandom_range(0, 255));
      default: return FIELD_BITS'($urandom);
    endcase
  endfunction

  function automatic plma_request_t op_req(input kind_t kind, input logic [POLICY_BITS-1:0] pol);
    plma_request_t r;
    r.kind         = kind;
    r.policy       = pol;
    r.ctrl_type    = TYPE_BITS'($urandom_range(0, 3));
    r.power_valid  = ($urandom_range(0, 4) != 0);
    r.power_mw     = pick_limit_value();
    r.window_valid = ($urandom_range(0, 4) != 0);
    r.window_ms    = pick_limit_value();
    r.duty_valid   = ($urandom_range(0, 4) != 0);
    r.duty_pct     = ($urandom_range(0, 7) == 0) ? DUTY_BITS'($urandom_range(101, 127))
                                                 : DUTY_BITS'($urandom_range(0, 100));
    r.drain_first  = 1'b0;
    return r;
  endfunction

  function automatic plma_request_t entry_req(input logic [TYPE_BITS-1:0] ct,
                                              input logic pv, input logic [FIELD_BITS-1:0] pw,
                                              input logic wv, input logic [FIELD_BITS-1:0] win,
                                              input logic dv, input logic [DUTY_BITS-1:0] duty);
    plma_request_t r;
    r = op_req(KIND_ENTRY, POLICY_BITS'($urandom_range(0, 15)));
    r.ctrl_type    = ct;
    r.power_valid  = pv;
    r.power_mw     = pw;
    r.window_valid = wv;
    r.window_ms    = win;
    r.duty_valid   = dv;
    r.duty_pct     = duty;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        resolve_request(offered);
        requests_taken++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() != 0 &&
                   !(pending_requests[0].drain_first && resolved_expected.size() != 0)) begin
        offered = pending_requests.pop_front();
        in_kind         <= offered.kind;
        in_policy       <= offered.policy;
        in_ctrl_type    <= offered.ctrl_type;
        in_power_valid  <= offered.power_valid;
        in_power_mw     <= offered.power_mw;
        in_window_valid <= offered.window_valid;
        in_window_ms    <= offered.window_ms;
        in_duty_valid   <= offered.duty_valid;
        in_duty_pct     <= offered.duty_pct;
        in_valid        <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
      long_hold_done = 1'b0;
      stall_tick = 0;
      stall_mode = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (resolved_expected.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual type %0d", $time, out_type);
        end else begin
          resolved_t w;
          w = resolved_expected.pop_front();
          check_field("out_type", 32'(w.ltype), 32'(out_type));
          check_field("res_power_valid", 32'(w.lim.pv), 32'(out_res_power_valid));
          check_field("res_power_mw", 32'(w.lim.pw), 32'(out_res_power_mw));
          check_field("res_window_valid", 32'(w.lim.wv), 32'(out_res_window_valid));
          check_field("res_window_ms", 32'(w.lim.win), 32'(out_res_window_ms));
          check_field("res_duty_valid", 32'(w.lim.dv), 32'(out_res_duty_valid));
          check_field("res_duty_pct", 32'(w.lim.duty), 32'(out_res_duty_pct));
          check_field("changed", 32'(w.changed), 32'(out_changed));
          check_field("last", 32'(w.last), 32'(out_last));
          results_checked++;
        end
      end
      stall_tick++;
      if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
      if (!long_hold_done && results_checked >= 15) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= stall_tick[2];
        endcase
      end
    end
  end

  initial begin
    plma_request_t r;
    int unsigned   useful;
    int unsigned   pick;
    int unsigned   n;
    logic [TYPE_BITS-1:0] ct;
    logic [NUM_TYPES-1:0] gen_seen;

    queue_request(op_req(KIND_COMMIT, 4'd0));
    // entry with no begin lands on policy 0
    queue_request(entry_req(2'd0, 1'b1, '1, 1'b1, '0, 1'b1, 7'd127));
    r = op_req(KIND_ENTRY, 4'd9);
    r.ctrl_type = 2'd3;
    queue_request(r);
    queue_request(entry_req(2'd0, 1'b1, 24'd5, 1'b1, 24'd5, 1'b1, 7'd5));
    queue_request(op_req(KIND_COMMIT, 4'd0));
    queue_request(op_req(KIND_COMMIT, 4'd0));
    queue_request(op_req(KIND_BEGIN, 4'd15));
    queue_request(entry_req(2'd1, 1'b0, 24'd123, 1'b1, '1, 1'b1, 7'd100));
    queue_request(entry_req(2'd2, 1'b1, '0, 1'b0, '1, 1'b0, 7'd127));
    queue_request(entry_req(2'd0, 1'b1, '1, 1'b0, '0, 1'b1, 7'd3));
    queue_request(op_req(KIND_COMMIT, 4'd0));
    r = op_req(KIND_BEGIN, 4'd5);
    r.drain_first = 1'b1;
    queue_request(r);
    queue_request(entry_req(2'd1, 1'b1, 24'd7, 1'b1, 24'd1, 1'b0, 7'd0));
    queue_request(entry_req(2'd2, 1'b1, '0, 1'b1, 24'd2, 1'b1, 7'd55));
    queue_request(op_req(KIND_COMMIT, 4'd0));
    // still open after commit
    queue_request(entry_req(2'd0, 1'b1, 24'd1, 1'b1, '1, 1'b1, 7'd64));
    queue_request(op_req(KIND_COMMIT, 4'd0));
    queue_request(op_req(KIND_CLEAR, 4'd5));
    queue_request(op_req(KIND_CLEAR, 4'd0));
    queue_request(op_req(KIND_COMMIT, 4'd0));
    queue_request(op_req(KIND_BEGIN, 4'd0));
    queue_request(op_req(KIND_COMMIT, 4'd0));
    queue_request(op_req(KIND_CLEAR, 4'd15));
    queue_request(op_req(KIND_COMMIT, 4'd0));

    useful = 0;
    gen_seen = '0;
    while (useful < RANDOM_REQUESTS) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        r = op_req(KIND_BEGIN, POLICY_BITS'($urandom_range(0, 15)));
        r.drain_first = (useful == 0) || ($urandom_range(0, 19) == 0);
        queue_request(r);
        useful++;
        gen_seen = '0;
        n = $urandom_range(1, 4);
        repeat (n) begin
          ct = ($urandom_range(0, 7) == 0) ? 2'd3 : TYPE_BITS'($urandom_range(0, 2));
          r = op_req(KIND_ENTRY, POLICY_BITS'($urandom_range(0, 15)));
          r.ctrl_type = ct;
          queue_request(r);
          if (ct < NUM_TYPES && !gen_seen[ct]) begin
            gen_seen[ct] = 1'b1;
            useful++;
          end
        end
        if ($urandom_range(0, 1)) begin
          queue_request(op_req(KIND_COMMIT, POLICY_BITS'($urandom_range(0, 15))));
          useful++;
        end
      end else if (pick == 7) begin
        queue_request(op_req(KIND_CLEAR, POLICY_BITS'($urandom_range(0, 15))));
        useful++;
      end else if (pick == 8) begin
        queue_request(op_req(KIND_COMMIT, POLICY_BITS'($urandom_range(0, 15))));
        useful++;
      end else begin
        ct = TYPE_BITS'($urandom_range(0, 3));
        r = op_req(KIND_ENTRY, POLICY_BITS'($urandom_range(0, 15)));
        r.ctrl_type = ct;
        queue_request(r);
        if (ct < NUM_TYPES && !gen_seen[ct]) begin
          gen_seen[ct] = 1'b1;
          useful++;
        end
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_valid || resolved_expected.size() != 0)
      @(negedge clk);
    repeat (END_SETTLE) @(posedge clk);

    $display("Run covered %0d requests including %0d commits; %0d type results compared.",
             requests_taken, commits_taken, results_checked);
    $display("Sender bursts and drain pauses, receiver stall patterns and one %0d-cycle hold.",
             LONG_HOLD_CYCLES);
    if (mismatches == 0 && resolved_expected.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- power_limit_min_arbiter.f -----
rtl/plma_pkg.sv
rtl/plma_ram.sv
rtl/plma_ctrl.sv
rtl/plma_dpath.sv
rtl/power_limit_min_arbiter.sv
tb/sv/tb_power_limit_min_arbiter.sv
